// ----- sv/lru_set_assoc_cache_model_core_defines.svh -----
// Assertion macros used by the checker file.
`ifndef LRU_SET_ASSOC_CACHE_MODEL_CORE_DEFINES_SVH
`define LRU_SET_ASSOC_CACHE_MODEL_CORE_DEFINES_SVH
// Implication checked on every rising clock edge outside reset.
`define LSC_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
// Next-cycle implication checked outside reset.
`define LSC_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`endif

// ----- sv/lsc_pkg.sv -----
// ----------------------------------------------------------------------------
// lsc_pkg
// Shared types and constants of the LRU set-associative cache model.
// ----------------------------------------------------------------------------
package lsc_pkg;

    localparam int MAX_SET_BITS_DEF = 6;
    localparam int MAX_WAYS_DEF     = 8;
    localparam int ADDR_WIDTH_DEF   = 64;

    // Request types
    localparam logic [1:0] REQ_IFETCH = 2'd0;
    localparam logic [1:0] REQ_LOAD   = 2'd1;
    localparam logic [1:0] REQ_STORE  = 2'd2;
    localparam logic [1:0] REQ_MODIFY = 2'd3;

    // Access outcomes
    localparam logic [1:0] OUT_HIT   = 2'd0;
    localparam logic [1:0] OUT_FILL  = 2'd1;
    localparam logic [1:0] OUT_EVICT = 2'd2;

    // Configuration register indexes
    localparam logic [1:0] CFG_SET_BITS = 2'd0;
    localparam logic [1:0] CFG_WAYS     = 2'd1;
    localparam logic [1:0] CFG_BLOCK    = 2'd2;

    localparam int CFG_W = 6;

    // Back-end sequencer states
    typedef enum logic [2:0] {
        BE_CLEAR,
        BE_IDLE,
        BE_READ,
        BE_UPDATE,
        BE_OUT
    } be_state_t;

endpackage

// ----- sv/lru_set_assoc_cache_model_core.sv -----
// Tag-only set-associative cache model with true LRU. Requests enter a
// two-entry queue at one beat per cycle while it is not full; instruction
// fetches are dropped there. The back end handles a load or store as a
// queue check, a set read from the tag and rank RAMs, a compare and
// write-back, and a result beat that waits on out_ready; a modify makes
// two accesses. After reset the back end first clears valid bits and
// ranks one set at a time (64 sets by default); requests wait in the
// queue meanwhile.
// ----------------------------------------------------------------------------
// lru_set_assoc_cache_model_core
// Top level: configuration registers, front end and back end.
// ----------------------------------------------------------------------------
module lru_set_assoc_cache_model_core #(
    parameter int MAX_SET_BITS = lsc_pkg::MAX_SET_BITS_DEF,
    parameter int MAX_WAYS     = lsc_pkg::MAX_WAYS_DEF,
    parameter int ADDR_WIDTH   = lsc_pkg::ADDR_WIDTH_DEF
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_we,
    input  logic [1:0]            cfg_index,
    input  logic [lsc_pkg::CFG_W-1:0] cfg_data,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  logic [1:0]            req_kind,
    input  logic [ADDR_WIDTH-1:0] address,
    output logic                  out_valid,
    input  logic                  out_ready,
    output logic [1:0]            outcome,
    output logic [2:0]            way_index,
    output logic [5:0]            set_index,
    output logic                  is_last,
    output logic [31:0]           hit_total,
    output logic [31:0]           miss_total,
    output logic [31:0]           evict_total
);

    localparam int SW = (MAX_SET_BITS > 0) ? MAX_SET_BITS : 1;

    logic [2:0] set_bits_reg;
    logic [3:0] ways_reg;
    logic [5:0] block_reg;
    logic                  q_valid, q_pop, q_modify;
    logic [SW-1:0]         q_set;
    logic [ADDR_WIDTH-1:0] q_tag;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            set_bits_reg <= 3'd4;
            ways_reg     <= 4'd1;
            block_reg    <= 6'd4;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                lsc_pkg::CFG_SET_BITS: set_bits_reg <= cfg_data[2:0];
                lsc_pkg::CFG_WAYS:     ways_reg     <= cfg_data[3:0];
                lsc_pkg::CFG_BLOCK:    block_reg    <= cfg_data[5:0];
                default: ;
            endcase
        end
    end

    lsc_front #(.MAX_SET_BITS(MAX_SET_BITS), .ADDR_WIDTH(ADDR_WIDTH)) u_front (
        .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_ready(in_ready),
        .req_kind(req_kind), .address(address), .set_bits(set_bits_reg),
        .block_bits(block_reg), .q_valid(q_valid), .q_pop(q_pop),
        .q_set(q_set), .q_tag(q_tag), .q_modify(q_modify));

    lsc_back #(.MAX_SET_BITS(MAX_SET_BITS), .MAX_WAYS(MAX_WAYS),
               .ADDR_WIDTH(ADDR_WIDTH)) u_back (
        .clk(clk), .rst_n(rst_n), .ways_in_use(ways_reg), .q_valid(q_valid),
        .q_pop(q_pop), .q_set(q_set), .q_tag(q_tag), .q_modify(q_modify),
        .out_valid(out_valid), .out_ready(out_ready), .outcome(outcome),
        .way_index(way_index), .set_index(set_index), .is_last(is_last),
        .hit_total(hit_total), .miss_total(miss_total),
        .evict_total(evict_total));

endmodule

// ----- sv/lsc_ram.sv -----
// ----------------------------------------------------------------------------
// lsc_ram
// Generic simple dual-port RAM (one write port, one read port) with registered read data.
// ----------------------------------------------------------------------------
module lsc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // write port and registered read port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ----- sv/lsc_front.sv -----
// ----------------------------------------------------------------------------
// lsc_front
// Accepts requests, drops instruction fetches, splits set index and tag,
// and queues the decoded accesses in a two-entry FIFO.
// ----------------------------------------------------------------------------
module lsc_front #(
    parameter int MAX_SET_BITS = lsc_pkg::MAX_SET_BITS_DEF,
    parameter int ADDR_WIDTH   = lsc_pkg::ADDR_WIDTH_DEF,
    localparam int SW = (MAX_SET_BITS > 0) ? MAX_SET_BITS : 1
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  logic [1:0]            req_kind,
    input  logic [ADDR_WIDTH-1:0] address,
    input  logic [2:0]            set_bits,
    input  logic [5:0]            block_bits,
    output logic                  q_valid,
    input  logic                  q_pop,
    output logic [SW-1:0]         q_set,
    output logic [ADDR_WIDTH-1:0] q_tag,
    output logic                  q_modify
);

    localparam int ENT = SW + ADDR_WIDTH + 1;

    logic [ENT-1:0] fifo_reg [2];
    logic           wr_ptr_reg, rd_ptr_reg;
    logic [1:0]     cnt_reg;
    logic           push;
    logic [3:0]     sb;
    logic [6:0]     tag_sh;
    logic [ADDR_WIDTH-1:0] set_full;
    logic [ADDR_WIDTH-1:0] tag;
    logic [SW-1:0]  set_mask;

    // effective set bits, clamped
    always_comb
    begin
        sb = ({1'b0, set_bits} > 4'(MAX_SET_BITS)) ? 4'(MAX_SET_BITS) : {1'b0, set_bits};
        tag_sh = 7'(block_bits) + 7'(sb);
        set_full = ({1'b0, block_bits} >= 7'(ADDR_WIDTH)) ? '0 : (address >> block_bits);
        tag = (tag_sh >= 7'(ADDR_WIDTH)) ? '0 : (address >> tag_sh);
        set_mask = SW'(({{SW{1'b0}}, 1'b1} << sb) - 1'b1);
    end

    assign in_ready = (cnt_reg != 2'd2);
    assign push     = in_valid && in_ready && (req_kind != lsc_pkg::REQ_IFETCH);
    assign q_valid  = (cnt_reg != 2'd0);
    assign {q_modify, q_set, q_tag} = fifo_reg[rd_ptr_reg];

    // decoded access queue
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            cnt_reg    <= 2'd0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= ~wr_ptr_reg;
            end
            if (q_pop)
            begin
                rd_ptr_reg <= ~rd_ptr_reg;
            end
            cnt_reg <= cnt_reg + 2'(push) - 2'(q_pop);
        end
    end

    // queue payload
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            fifo_reg[wr_ptr_reg] <= {(req_kind == lsc_pkg::REQ_MODIFY),
                                     SW'(set_full) & set_mask, tag};
        end
    end

endmodule

// ----- sv/lsc_back.sv -----
// ----------------------------------------------------------------------------
// lsc_back
// Carries out accesses: reads a set, compares tags, picks the way, writes
// back tags, valid bits and LRU ranks, updates totals and presents the
// result beat. After reset it clears valid bits and ranks one set a cycle.
// ----------------------------------------------------------------------------
module lsc_back #(
    parameter int MAX_SET_BITS = lsc_pkg::MAX_SET_BITS_DEF,
    parameter int MAX_WAYS     = lsc_pkg::MAX_WAYS_DEF,
    parameter int ADDR_WIDTH   = lsc_pkg::ADDR_WIDTH_DEF,
    localparam int SW = (MAX_SET_BITS > 0) ? MAX_SET_BITS : 1
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic [3:0]            ways_in_use,
    input  logic                  q_valid,
    output logic                  q_pop,
    input  logic [SW-1:0]         q_set,
    input  logic [ADDR_WIDTH-1:0] q_tag,
    input  logic                  q_modify,
    output logic                  out_valid,
    input  logic                  out_ready,
    output logic [1:0]            outcome,
    output logic [2:0]            way_index,
    output logic [5:0]            set_index,
    output logic                  is_last,
    output logic [31:0]           hit_total,
    output logic [31:0]           miss_total,
    output logic [31:0]           evict_total
);

    localparam int NSETS = 1 << MAX_SET_BITS;
    localparam int WW    = (MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1;
    localparam int RW    = WW;
    localparam int CW    = $clog2(MAX_WAYS + 1);
    localparam logic [RW-1:0] RMAX = RW'(MAX_WAYS - 1);

    lsc_pkg::be_state_t state_reg, state_next;

    logic [RW:0]      rword_rd [MAX_WAYS];
    logic [RW:0]      rword_wr [MAX_WAYS];
    logic [RW-1:0]    rank_rd [MAX_WAYS];
    logic [ADDR_WIDTH-1:0] tag_rd [MAX_WAYS];
    logic [RW-1:0]    rank_wr [MAX_WAYS];
    logic             tag_we  [MAX_WAYS];

    logic             second_reg;
    logic [31:0]      hit_reg, miss_reg, evict_reg;
    logic [1:0]       oc_reg;
    logic [WW-1:0]    way_reg;
    logic             last_reg;
    logic [SW-1:0]    clr_reg;
    logic [SW-1:0]    rank_waddr;
    logic             clr_we;

    logic [CW-1:0]    ways;
    logic [MAX_WAYS-1:0] used, vbits, hitv, freev;
    logic             hit, anyfree;
    logic [WW-1:0]    hway, fway, lway, sel;
    logic [RW-1:0]    old, best;
    logic             sel_valid;
    logic [1:0]       oc;
    logic             do_upd;

    // effective way count
    always_comb
    begin
        if (ways_in_use == 4'd0)
            ways = CW'(1);
        else if (int'(ways_in_use) > MAX_WAYS)
            ways = CW'(MAX_WAYS);
        else
            ways = CW'(ways_in_use);
    end

    assign rank_waddr = clr_we ? clr_reg : q_set;

    // per-way tag storage and {valid, rank} storage
    for (genvar w = 0; w < MAX_WAYS; w++)
    begin : g_way
        lsc_ram #(.WIDTH(ADDR_WIDTH), .DEPTH(NSETS)) u_tag (
            .clk(clk), .we(tag_we[w]), .waddr(q_set), .wdata(q_tag),
            .raddr(q_set), .rdata(tag_rd[w]));
        lsc_ram #(.WIDTH(RW + 1), .DEPTH(NSETS)) u_rank (
            .clk(clk), .we(clr_we || (do_upd && used[w])), .waddr(rank_waddr),
            .wdata(rword_wr[w]), .raddr(q_set), .rdata(rword_rd[w]));
        assign rank_rd[w]  = rword_rd[w][RW-1:0];
        assign vbits[w]    = rword_rd[w][RW];
        assign rword_wr[w] = clr_we ? '0 : {vbits[w] || (WW'(w) == sel), rank_wr[w]};
        assign used[w]  = (CW'(w) < ways);
        assign hitv[w]  = used[w] && vbits[w] && (tag_rd[w] == q_tag);
        assign freev[w] = used[w] && !vbits[w];
    end

    // way selection: hit, lowest free, or oldest
    always_comb
    begin
        hway = '0;
        fway = '0;
        lway = '0;
        best = rank_rd[0];
        for (int i = MAX_WAYS - 1; i >= 0; i--)
        begin
            if (hitv[i]) hway = WW'(i);
            if (freev[i]) fway = WW'(i);
        end
        for (int i = 1; i < MAX_WAYS; i++)
        begin
            if (used[i] && (rank_rd[i] > best))
            begin
                best = rank_rd[i];
                lway = WW'(i);
            end
        end
        hit     = |hitv;
        anyfree = |freev;
        if (hit)
        begin
            sel = hway;
            oc  = lsc_pkg::OUT_HIT;
        end
        else if (anyfree)
        begin
            sel = fway;
            oc  = lsc_pkg::OUT_FILL;
        end
        else
        begin
            sel = lway;
            oc  = lsc_pkg::OUT_EVICT;
        end
        sel_valid = hit || !anyfree;
        old = rank_rd[sel];
        for (int i = 0; i < MAX_WAYS; i++)
        begin
            rank_wr[i] = rank_rd[i];
            if (WW'(i) == sel)
                rank_wr[i] = '0;
            else if (vbits[i] && (!sel_valid || rank_rd[i] < old) && rank_rd[i] < RMAX)
                rank_wr[i] = rank_rd[i] + 1'b1;
            tag_we[i] = do_upd && !hit && (WW'(i) == sel);
        end
    end

    // sequencer: clear after reset, read set, update, present beat
    always_comb
    begin
        state_next = state_reg;
        q_pop      = 1'b0;
        do_upd     = 1'b0;
        clr_we     = 1'b0;
        unique case (state_reg)
            lsc_pkg::BE_CLEAR:
            begin
                clr_we = 1'b1;
                if (clr_reg == SW'(NSETS - 1))
                    state_next = lsc_pkg::BE_IDLE;
            end
            lsc_pkg::BE_IDLE:
            begin
                if (q_valid)
                    state_next = lsc_pkg::BE_READ;
            end
            lsc_pkg::BE_READ:
            begin
                state_next = lsc_pkg::BE_UPDATE;
            end
            lsc_pkg::BE_UPDATE:
            begin
                do_upd     = 1'b1;
                state_next = lsc_pkg::BE_OUT;
                if (!q_modify || second_reg)
                    q_pop = 1'b1;
            end
            lsc_pkg::BE_OUT:
            begin
                if (out_ready)
                    state_next = (last_reg) ? lsc_pkg::BE_IDLE : lsc_pkg::BE_READ;
            end
            default:
            begin
                state_next = lsc_pkg::BE_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= lsc_pkg::BE_CLEAR;
            clr_reg    <= '0;
            second_reg <= 1'b0;
            hit_reg    <= '0;
            miss_reg   <= '0;
            evict_reg  <= '0;
            last_reg   <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (clr_we)
            begin
                clr_reg <= clr_reg + SW'(1);
            end
            if (do_upd)
            begin
                last_reg   <= q_pop;
                second_reg <= !q_pop;
                if (hit)
                    hit_reg <= hit_reg + 32'd1;
                else
                    miss_reg <= miss_reg + 32'd1;
                if (!hit && !anyfree)
                    evict_reg <= evict_reg + 32'd1;
            end
        end
    end

    // result payload
    always_ff @(posedge clk)
    begin
        if (do_upd)
        begin
            oc_reg  <= oc;
            way_reg <= sel;
            set_index <= 6'(q_set);
        end
    end

    assign out_valid   = (state_reg == lsc_pkg::BE_OUT);
    assign outcome     = oc_reg;
    assign way_index   = 3'(way_reg);
    assign is_last     = last_reg;
    assign hit_total   = hit_reg;
    assign miss_total  = miss_reg;
    assign evict_total = evict_reg;

endmodule

// ----- sv/lsc_checker.sv -----
// ----------------------------------------------------------------------------
// lsc_checker
// Port-level checks on the result channel of the cache model.
// ----------------------------------------------------------------------------
`include "lru_set_assoc_cache_model_core_defines.svh"
module lsc_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        out_valid,
    input logic        out_ready,
    input logic [1:0]  outcome,
    input logic [31:0] hit_total,
    input logic [31:0] miss_total,
    input logic [31:0] evict_total
);

    // a stalled beat holds
    `LSC_ASSERT_NXT(a_hold, clk, rst_n, out_valid && !out_ready, out_valid && $stable(outcome), "result beat dropped while stalled")
    // outcome code is meaningful
    `LSC_ASSERT_IMP(a_code, clk, rst_n, out_valid, outcome <= lsc_pkg::OUT_EVICT, "bad outcome code")
    // eviction shows in the eviction total
    `LSC_ASSERT_IMP(a_evict, clk, rst_n, out_valid && outcome == lsc_pkg::OUT_EVICT, evict_total != 32'd0 && miss_total != 32'd0, "eviction not counted")
    // hit shows in the hit total
    `LSC_ASSERT_IMP(a_hit, clk, rst_n, out_valid && outcome == lsc_pkg::OUT_HIT, hit_total != 32'd0, "hit not counted")

endmodule

bind lru_set_assoc_cache_model_core lsc_checker u_lsc_checker (
    .clk(clk), .rst_n(rst_n), .out_valid(out_valid), .out_ready(out_ready),
    .outcome(outcome), .hit_total(hit_total), .miss_total(miss_total),
    .evict_total(evict_total));

// ----- bench/lru_set_assoc_cache_model_core_tb.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// lru_set_assoc_cache_model_core_tb
// Self-checking bench for the tag-only LRU cache model. A scoreboard keeps
// its own copy of the sets, ranks and totals, predicts every access beat and
// compares it field by field. Geometry changes between idle phases, and
// both handshakes idle at random.
// ----------------------------------------------------------------------------
module lru_set_assoc_cache_model_core_tb;

    localparam int NSETS = 64;
    localparam int NWAYS = 8;
    localparam int LIMIT = 1000000;

    typedef struct {
        logic [1:0]  outcome;
        logic [2:0]  way;
        logic [5:0]  set;
        logic        last;
        logic [31:0] hits;
        logic [31:0] misses;
        logic [31:0] evicts;
    } access_t;

    // ------------------------------------------------------------------------
    // Scoreboard: cache shadow plus queue of expected access beats
    // ------------------------------------------------------------------------
    class cache_scoreboard;
        bit          valid_q[NSETS][NWAYS];
        logic [63:0] tag_q[NSETS][NWAYS];
        int unsigned rank_q[NSETS][NWAYS];
        logic [31:0] hits, misses, evicts;
        int unsigned set_bits, ways, block_bits;
        access_t     pending[$];
        int          errors;

        function new();
            errors = 0;
            hits = 0;
            misses = 0;
            evicts = 0;
            set_bits = 4;
            ways = 1;
            block_bits = 4;
            foreach (valid_q[s, w])
            begin
                valid_q[s][w] = 0;
                rank_q[s][w] = 0;
            end
        endfunction

        function void write_reg(logic [1:0] idx, logic [5:0] val);
            if (idx == lsc_pkg::CFG_SET_BITS)
                set_bits = val[2:0];
            else if (idx == lsc_pkg::CFG_WAYS)
                ways = val[3:0];
            else if (idx == lsc_pkg::CFG_BLOCK)
                block_bits = val;
        endfunction

        // Move a way to most recent; newer valid ways age by one
        function void promote(int s, int nw, int w, bit was_valid);
            int unsigned old;
            old = was_valid ? rank_q[s][w] : NWAYS;
            for (int i = 0; i < nw; i++)
            begin
                if (i != w && valid_q[s][i] && rank_q[s][i] < old && rank_q[s][i] < NWAYS - 1)
                    rank_q[s][i]++;
            end
            rank_q[s][w] = 0;
        endfunction

        function void predict_access(logic [63:0] addr, bit last);
            int unsigned sb, nw, s, w;
            logic [63:0] tag;
            access_t e;
            bit found;
            sb = (set_bits > 6) ? 6 : set_bits;
            nw = (ways == 0) ? 1 : ((ways > NWAYS) ? NWAYS : ways);
            s = (block_bits >= 64) ? 0 : int'((addr >> block_bits) & ((64'd1 << sb) - 1));
            tag = (block_bits + sb >= 64) ? 64'd0 : (addr >> (block_bits + sb));
            found = 0;
            w = 0;
            for (int i = 0; i < nw && !found; i++)
            begin
                if (valid_q[s][i] && tag_q[s][i] == tag)
                begin
                    w = i;
                    found = 1;
                end
            end
            if (found)
            begin
                e.outcome = lsc_pkg::OUT_HIT;
                hits++;
                promote(s, nw, w, 1);
            end
            else
            begin
                misses++;
                for (int i = 0; i < nw && !found; i++)
                begin
                    if (!valid_q[s][i])
                    begin
                        w = i;
                        found = 1;
                    end
                end
                if (found)
                begin
                    e.outcome = lsc_pkg::OUT_FILL;
                    promote(s, nw, w, 0);
                    valid_q[s][w] = 1;
                end
                else
                begin
                    e.outcome = lsc_pkg::OUT_EVICT;
                    evicts++;
                    w = 0;
                    for (int i = 1; i < nw; i++)
                        if (rank_q[s][i] > rank_q[s][w])
                            w = i;
                    promote(s, nw, w, 1);
                end
                tag_q[s][w] = tag;
            end
            e.way = w[2:0];
            e.set = s[5:0];
            e.last = last;
            e.hits = hits;
            e.misses = misses;
            e.evicts = evicts;
            pending.push_back(e);
        endfunction

        function void note_request(logic [1:0] kind, logic [63:0] addr);
            if (kind == lsc_pkg::REQ_IFETCH)
                return;
            if (kind == lsc_pkg::REQ_MODIFY)
                predict_access(addr, 0);
            predict_access(addr, 1);
        endfunction

        function void check_result(access_t got);
            access_t e;
            if (pending.size() == 0)
            begin
                $display("%0t: unexpected beat outcome=%0d way=%0d set=%0d",
                         $time, got.outcome, got.way, got.set);
                errors++;
                return;
            end
            e = pending.pop_front();
            if (got.outcome !== e.outcome)
                report("outcome", e.outcome, got.outcome);
            if (got.way !== e.way)
                report("way_index", e.way, got.way);
            if (got.set !== e.set)
                report("set_index", e.set, got.set);
            if (got.last !== e.last)
                report("is_last", e.last, got.last);
            if (got.hits !== e.hits)
                report("hit_total", e.hits, got.hits);
            if (got.misses !== e.misses)
                report("miss_total", e.misses, got.misses);
            if (got.evicts !== e.evicts)
                report("evict_total", e.evicts, got.evicts);
        endfunction

        function void report(string field, logic [31:0] exp_v, logic [31:0] act_v);
            $display("%0t: %s mismatch expected %0h actual %0h", $time, field, exp_v, act_v);
            errors++;
        endfunction
    endclass

    logic        clk;
    logic        rst_n;
    logic        cfg_we;
    logic [1:0]  cfg_index;
    logic [5:0]  cfg_data;
    logic        in_valid;
    logic        in_ready;
    logic [1:0]  req_kind;
    logic [63:0] address;
    logic        out_valid;
    logic        out_ready;
    logic [1:0]  outcome;
    logic [2:0]  way_index;
    logic [5:0]  set_index;
    logic        is_last;
    logic [31:0] hit_total;
    logic [31:0] miss_total;
    logic [31:0] evict_total;

    cache_scoreboard sb;
    bit          quiet;
    bit          hold_rx;
    int unsigned cycles;
    logic [63:0] tag_pool[16];

    lru_set_assoc_cache_model_core dut (
        .clk(clk), .rst_n(rst_n),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
        .in_valid(in_valid), .in_ready(in_ready),
        .req_kind(req_kind), .address(address),
        .out_valid(out_valid), .out_ready(out_ready),
        .outcome(outcome), .way_index(way_index), .set_index(set_index),
        .is_last(is_last), .hit_total(hit_total), .miss_total(miss_total),
        .evict_total(evict_total)
    );

    initial
    begin
        clk = 0;
        forever #5 clk = ~clk;
    end

    // Result side: sample beats at the edge
    always @(posedge clk)
    begin
        access_t r;
        if (rst_n && out_valid && out_ready)
        begin
            r.outcome = outcome;
            r.way = way_index;
            r.set = set_index;
            r.last = is_last;
            r.hits = hit_total;
            r.misses = miss_total;
            r.evicts = evict_total;
            sb.check_result(r);
        end
    end

    // Receiver ready: random stalls, one long hold on request
    initial
    begin
        out_ready = 0;
        @(posedge rst_n);
        forever
        begin
            if (hold_rx)
            begin
                out_ready <= 0;
                repeat (400) @(posedge clk);
                hold_rx = 0;
            end
            else if (!quiet && $urandom_range(0, 9) == 0)
            begin
                out_ready <= 0;
                repeat ($urandom_range(1, 18)) @(posedge clk);
            end
            else
            begin
                out_ready <= 1;
                @(posedge clk);
            end
        end
    end

    // Watchdog
    always @(posedge clk)
    begin
        cycles++;
        if (cycles > LIMIT)
        begin
            $display("lru_set_assoc_cache_model_core verification failed");
            $finish;
        end
    end

    // One register write; the caller drops cfg_we after the last one
    task automatic write_reg(logic [1:0] idx, logic [5:0] val);
        cfg_we <= 1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge clk);
        sb.write_reg(idx, val);
    endtask

    task automatic drain();
        in_valid <= 0;
        while (sb.pending.size() != 0)
            @(posedge clk);
        repeat (20) @(posedge clk);
    endtask

    task automatic set_geometry(int unsigned s_bits, int unsigned n_ways, int unsigned b_bits);
        drain();
        write_reg(lsc_pkg::CFG_SET_BITS, 6'(s_bits));
        write_reg(lsc_pkg::CFG_WAYS, 6'(n_ways));
        write_reg(lsc_pkg::CFG_BLOCK, 6'(b_bits));
        cfg_we <= 0;
        foreach (tag_pool[i])
            tag_pool[i] = {$urandom, $urandom};
    endtask

    // One request beat, held until accepted
    task automatic send_req(logic [1:0] kind, logic [63:0] addr);
        in_valid <= 1;
        req_kind <= kind;
        address <= addr;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        sb.note_request(kind, addr);
        if (!quiet && $urandom_range(0, 7) == 0)
        begin
            in_valid <= 0;
            repeat ($urandom_range(1, 18)) @(posedge clk);
        end
    endtask

    // Address built from a small tag pool and a few sets to force reuse
    function automatic logic [63:0] pick_addr();
        int unsigned sbits;
        logic [63:0] a, offs;
        if ($urandom_range(0, 6) == 0)
            return {$urandom, $urandom};
        sbits = (sb.set_bits > 6) ? 6 : sb.set_bits;
        offs = {$urandom, $urandom};
        if (sb.block_bits < 64)
            offs = offs & ((64'd1 << sb.block_bits) - 1);
        a = (tag_pool[$urandom_range(0, (sb.ways + 2 > 15) ? 15 : sb.ways + 2)]
             << (sb.block_bits + sbits))
            | (64'($urandom_range(0, 3)) << sb.block_bits) | offs;
        return a;
    endfunction

    task automatic run_phase(int unsigned n, bit pressure);
        int unsigned sent;
        logic [1:0] kind;
        sent = 0;
        while (sent < n)
        begin
            if (pressure && sent == n / 3)
                hold_rx = 1;
            if (pressure && sent == (2 * n) / 3)
                drain();
            kind = 2'($urandom_range(0, 3));
            send_req(kind, pick_addr());
            sent++;
        end
    endtask

    initial
    begin
        sb = new();
        quiet = 0;
        hold_rx = 0;
        cycles = 0;
        rst_n = 0;
        cfg_we = 0;
        cfg_index = lsc_pkg::CFG_SET_BITS;
        cfg_data = 0;
        in_valid = 0;
        req_kind = lsc_pkg::REQ_IFETCH;
        address = 0;
        repeat (4) @(posedge clk);
        rst_n <= 1;
        @(posedge clk);

        // Directed: reset geometry, one way per set
        send_req(lsc_pkg::REQ_IFETCH, 64'h0);
        send_req(lsc_pkg::REQ_LOAD, 64'h0);
        send_req(lsc_pkg::REQ_LOAD, 64'h0);
        send_req(lsc_pkg::REQ_STORE, '1);
        send_req(lsc_pkg::REQ_MODIFY, 64'h8000_0000_0000_0010);
        send_req(lsc_pkg::REQ_LOAD, 64'h0000_0000_0000_0100);
        send_req(lsc_pkg::REQ_STORE, 64'h5555_5555_5555_5555);
        send_req(lsc_pkg::REQ_MODIFY, 64'hAAAA_AAAA_AAAA_AAAA);
        send_req(lsc_pkg::REQ_IFETCH, '1);
        // Full associativity in one set, then LRU victim choice
        set_geometry(0, 4, 0);
        for (int i = 0; i < 5; i++)
            send_req(lsc_pkg::REQ_LOAD, 64'(i));
        send_req(lsc_pkg::REQ_LOAD, 64'd2);
        send_req(lsc_pkg::REQ_MODIFY, 64'd9);
        send_req(lsc_pkg::REQ_STORE, 64'd3);
        // Oversized geometry values
        set_geometry(7, 0, 63);
        send_req(lsc_pkg::REQ_LOAD, '1);
        send_req(lsc_pkg::REQ_MODIFY, 64'h1);
        set_geometry(6, 15, 32);
        send_req(lsc_pkg::REQ_LOAD, 64'hFFFF_FFFF_0000_0000);
        send_req(lsc_pkg::REQ_STORE, 64'h0000_003F_0000_0000);

        // Random phases across geometries, extremes among them
        set_geometry(6, 8, 0);
        run_phase(160, 1);
        set_geometry(0, 1, 32);
        run_phase(150, 0);
        set_geometry(3, 2, 5);
        run_phase(160, 0);
        set_geometry(2, 8, 40);
        run_phase(150, 0);
        set_geometry(1, 3, 12);
        run_phase(150, 0);
        set_geometry(4, 1, 4);
        run_phase(150, 0);
        for (int p = 0; p < 4; p++)
        begin
            set_geometry($urandom_range(0, 7), $urandom_range(0, 15), $urandom_range(0, 63));
            run_phase(150, 0);
        end
        set_geometry(5, 6, 2);
        quiet = 1;
        run_phase(120, 0);

        drain();
        if (sb.errors == 0 && sb.pending.size() == 0)
            $display("lru_set_assoc_cache_model_core verification clean");
        else
            $display("lru_set_assoc_cache_model_core verification failed");
        $finish;
    end
endmodule
